[hdl/act_pkg.sv]
// ----------------------------------------------------------------------------
// act_pkg
// shared types and constants for the arbitrage cycle tracker
// ----------------------------------------------------------------------------
package act_pkg;

    localparam int NUM_PAIRS_DEF      = 64;
    localparam int NUM_CYCLES_DEF     = 256;
    localparam int CYCLE_LEN_DEF      = 4;
    localparam int RATE_FRAC_BITS_DEF = 20;

    localparam int FUNC_W  = 2;
    localparam int PAIR_W  = 6;
    localparam int RATE_W  = 32;
    localparam int CYCLE_W = 8;
    localparam int SLOT_W  = 2;
    localparam int CFG_W   = 9;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_UPDATE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MRD,
        ST_MWAIT,
        ST_SLOT,
        ST_RWAIT,
        ST_MUL,
        ST_WB,
        ST_PRD,
        ST_PWAIT,
        ST_CMP,
        ST_NEXT,
        ST_DONE
    } state_t;

endpackage

[hdl/act_mul.sv]
// ----------------------------------------------------------------------------
// act_mul
// registered 32x32 unsigned multiplier shared by profit and query work
// ----------------------------------------------------------------------------
module act_mul (
    input  logic                       clk,
    input  logic [act_pkg::RATE_W-1:0] a,
    input  logic [act_pkg::RATE_W-1:0] b,
    output logic [2*act_pkg::RATE_W-1:0] p
);
    import act_pkg::*;

    logic [2*RATE_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;
endmodule

[hdl/arbitrage_cycle_tracker_top.sv]
// ----------------------------------------------------------------------------
// arbitrage_cycle_tracker_top
// exchange rate store with per-cycle profit tracking and arbitrage query
// ----------------------------------------------------------------------------
// One item at a time; in_ready is low while an item is processed. After reset
// the member used bits are cleared one entry at a time, with in_ready low,
// over 2**($clog2(NUM_CYCLES) + $clog2(CYCLE_LEN)) entries (1024 by default).
// A slot is read in the MRD, MWAIT and SLOT states, with RWAIT and MUL added
// when its rate is multiplied in. A load rewrites one slot and recomputes the
// profit of its cycle. An update walks every cycle through the member, rate
// and profit memories with one shared multiplier; a cycle that holds the pair
// gets a further pass over its slots that recomputes the profit. A query scans
// the cycles below cycles_in_use (at most NUM_CYCLES) and stops at the first
// hit; a query with an unknown old rate and an unused func go straight to the
// result. The result waits in an output register, so the next item can be
// taken while it waits; a finished item is held until that register is free.
module arbitrage_cycle_tracker_top #(
    parameter int NUM_PAIRS      = act_pkg::NUM_PAIRS_DEF,
    parameter int NUM_CYCLES     = act_pkg::NUM_CYCLES_DEF,
    parameter int CYCLE_LEN      = act_pkg::CYCLE_LEN_DEF,
    parameter int RATE_FRAC_BITS = act_pkg::RATE_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [act_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [act_pkg::FUNC_W-1:0]  func,
    input  logic [act_pkg::PAIR_W-1:0]  pair,
    input  logic [act_pkg::RATE_W-1:0]  rate,
    input  logic [act_pkg::CYCLE_W-1:0] cycle,
    input  logic [act_pkg::SLOT_W-1:0]  slot,
    input  logic                        slot_used,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [act_pkg::CYCLE_W-1:0] hit_cycle
);
    import act_pkg::*;

    localparam int PI_W   = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
    localparam int CI_W   = (NUM_CYCLES > 1) ? $clog2(NUM_CYCLES) : 1;
    localparam int SI_W   = $clog2(CYCLE_LEN);
    localparam int MI_W   = CI_W + SI_W;
    localparam int MEM_D  = 1 << MI_W;
    localparam int CC_W   = CI_W + 1;
    localparam int SC_W   = SI_W + 1;
    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1) << RATE_FRAC_BITS;

    // memories
    logic [RATE_W-1:0] rate_mem [NUM_PAIRS];
    logic [PAIR_W-1:0] mpair_mem [MEM_D];
    logic              mused_mem [MEM_D];
    logic [RATE_W-1:0] profit_mem [NUM_CYCLES];
    logic              pknown_mem [NUM_CYCLES];
    logic [NUM_PAIRS-1:0] rate_known_reg;

    state_t state_reg, state_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [PAIR_W-1:0]  pair_reg;
    logic [RATE_W-1:0]  rate_in_reg;
    logic [CC_W-1:0]    cyc_reg, cyc_next;
    logic [SC_W-1:0]    slot_reg, slot_next;
    logic               recomp_reg, recomp_next;   // update: second pass over slots
    logic               holds_reg, holds_next;
    logic               known_reg, known_next;
    logic [RATE_W-1:0]  acc_reg, acc_next;
    logic [RATE_W-1:0]  old_rate_reg;
    logic [CFG_W-1:0]   cfg_reg;
    logic               out_valid_reg, found_reg, found_next;
    logic [CYCLE_W-1:0] hit_reg, hit_next;
    logic               out_found_reg;
    logic [CYCLE_W-1:0] out_hit_reg;
    logic               out_load;

    logic [PAIR_W-1:0]  mpair_q;
    logic               mused_q;
    logic [RATE_W-1:0]  rate_q, profit_q;
    logic               pknown_q;
    logic [RATE_W-1:0]  mul_a, mul_b;
    logic [2*RATE_W-1:0] mul_p;
    logic [2*RATE_W-1:0] shifted;
    logic [CC_W-1:0]    limit;

    logic [CI_W-1:0] cyc_idx;
    logic [SI_W-1:0] slot_idx;
    logic [MI_W-1:0] mem_addr;
    logic            pair_ok_q;

    // used bits are cleared entry by entry after reset
    logic            clr_busy_reg;
    logic [MI_W-1:0] clr_addr_reg;

    assign cyc_idx  = cyc_reg[CI_W-1:0];
    assign slot_idx = slot_reg[SI_W-1:0];
    assign mem_addr = {cyc_idx, slot_idx};

    logic in_fire;
    assign in_ready  = (state_reg == ST_IDLE) && !clr_busy_reg;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;
    assign hit_cycle = out_hit_reg;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    logic load_ok;
    assign load_ok = (32'(cycle) < 32'(NUM_CYCLES)) && (32'(slot) < 32'(CYCLE_LEN));
    assign pair_ok_q = 32'(mpair_q) < 32'(NUM_PAIRS);

    // old rate of a query is read while the item is taken
    logic [PI_W-1:0] rd_pair;
    assign rd_pair = (state_reg == ST_IDLE) ? pair[PI_W-1:0] : mpair_q[PI_W-1:0];

    assign limit = (32'(cfg_reg) < 32'(NUM_CYCLES)) ? CC_W'(cfg_reg) : CC_W'(NUM_CYCLES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == MI_W'(MEM_D - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // memory ports, registered reads
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mused_mem[clr_addr_reg] <= 1'b0;
        end
        else if (in_fire && func_t'(func) == FUNC_LOAD && load_ok)
        begin
            mpair_mem[{cycle[CI_W-1:0], slot[SI_W-1:0]}] <= pair;
            mused_mem[{cycle[CI_W-1:0], slot[SI_W-1:0]}] <= slot_used;
        end
        mpair_q <= mpair_mem[mem_addr];
        mused_q <= mused_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && func_t'(func) == FUNC_UPDATE && 32'(pair) < 32'(NUM_PAIRS))
        begin
            rate_mem[pair[PI_W-1:0]] <= rate;
        end
        rate_q <= rate_mem[rd_pair];
    end

    // a cycle that holds a pair has been loaded, so its known bit is written
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WB)
        begin
            profit_mem[cyc_idx] <= acc_reg;
            pknown_mem[cyc_idx] <= known_reg;
        end
        profit_q <= profit_mem[cyc_idx];
        pknown_q <= pknown_mem[cyc_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_known_reg <= '0;
            cfg_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cfg_reg <= cfg_data;
            if (in_fire && func_t'(func) == FUNC_UPDATE && 32'(pair) < 32'(NUM_PAIRS))
                rate_known_reg[pair[PI_W-1:0]] <= 1'b1;
        end
    end

    logic used_now;
    assign used_now = mused_q;

    act_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign mul_a = (state_reg == ST_CMP || state_reg == ST_PWAIT) ? profit_q : acc_reg;
    assign mul_b = (state_reg == ST_CMP || state_reg == ST_PWAIT) ? rate_in_reg : rate_q;
    assign shifted = mul_p >> RATE_FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_START)
            old_rate_reg <= rate_q;
        if (in_fire)
        begin
            func_reg    <= func;
            pair_reg    <= pair;
            rate_in_reg <= rate;
        end
    end

    // next state
    always_comb
    begin
        state_next  = state_reg;
        cyc_next    = cyc_reg;
        slot_next   = slot_reg;
        recomp_next = recomp_reg;
        holds_next  = holds_reg;
        known_next  = known_reg;
        acc_next    = acc_reg;
        found_next  = found_reg;
        hit_next    = hit_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    found_next  = 1'b0;
                    hit_next    = '0;
                    cyc_next    = CC_W'(cycle);
                    slot_next   = '0;
                    acc_next    = RATE_ONE;
                    known_next  = 1'b1;
                    holds_next  = 1'b0;
                    recomp_next = 1'b0;
                    priority case (func_t'(func))
                        FUNC_LOAD:   state_next = load_ok ? ST_MRD : ST_DONE;
                        FUNC_UPDATE:
                        begin
                            cyc_next   = '0;
                            state_next = (32'(pair) < 32'(NUM_PAIRS)) ? ST_MRD : ST_DONE;
                        end
                        FUNC_QUERY:
                        begin
                            cyc_next   = '0;
                            state_next = (32'(pair) < 32'(NUM_PAIRS) &&
                                          rate_known_reg[pair[PI_W-1:0]]) ? ST_START : ST_DONE;
                        end
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_START: state_next = (cyc_reg < limit) ? ST_MRD : ST_DONE;
            ST_MRD:   state_next = ST_MWAIT;
            ST_MWAIT: state_next = ST_SLOT;
            ST_SLOT:
            begin
                // member data valid; check holds / fetch rate
                if (used_now && mpair_q == pair_reg)
                    holds_next = 1'b1;
                if (func_t'(func_reg) == FUNC_QUERY ||
                    (func_t'(func_reg) == FUNC_UPDATE && !recomp_reg))
                begin
                    state_next = ST_NEXT;
                end
                else if (used_now && (!pair_ok_q || !rate_known_reg[mpair_q[PI_W-1:0]]))
                begin
                    known_next = 1'b0;
                    state_next = ST_WB;
                end
                else if (used_now && known_reg)
                    state_next = ST_RWAIT;
                else
                    state_next = ST_NEXT;
            end
            ST_RWAIT: state_next = ST_MUL;
            ST_MUL:
            begin
                acc_next   = (shifted[2*RATE_W-1:RATE_W] != '0) ? '1 : shifted[RATE_W-1:0];
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (32'(slot_reg) + 1 < 32'(CYCLE_LEN))
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_MRD;
                end
                else
                begin
                    slot_next = '0;
                    priority case (func_t'(func_reg))
                        FUNC_QUERY:
                            state_next = holds_reg ? ST_PRD : ST_CMP;
                        FUNC_UPDATE:
                            if (!recomp_reg && holds_reg)
                            begin
                                recomp_next = 1'b1;
                                state_next  = ST_MRD;
                            end
                            else
                                state_next = recomp_reg ? ST_WB : ST_CMP;
                        default: state_next = ST_WB;
                    endcase
                end
            end
            ST_WB:
            begin
                if (func_t'(func_reg) == FUNC_LOAD)
                    state_next = ST_DONE;
                else
                    state_next = ST_CMP;
            end
            ST_PRD:   state_next = ST_PWAIT;
            ST_PWAIT: state_next = ST_CMP;
            ST_CMP:
            begin
                // query compare (only when holds), then advance cycle
                if (func_t'(func_reg) == FUNC_QUERY && holds_reg && pknown_q &&
                    mul_p > ({32'd0, old_rate_reg} << RATE_FRAC_BITS))
                begin
                    found_next = 1'b1;
                    hit_next   = CYCLE_W'(cyc_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    cyc_next    = cyc_reg + 1'b1;
                    slot_next   = '0;
                    holds_next  = 1'b0;
                    recomp_next = 1'b0;
                    known_next  = 1'b1;
                    acc_next    = RATE_ONE;
                    if (func_t'(func_reg) == FUNC_QUERY)
                        state_next = (cyc_reg + 1'b1 < limit) ? ST_MRD : ST_DONE;
                    else
                        state_next = (32'(cyc_reg) + 1 < 32'(NUM_CYCLES)) ? ST_MRD : ST_DONE;
                end
            end
            // wait here while the output register still holds an item
            ST_DONE:  state_next = out_load ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            hit_reg       <= '0;
            out_found_reg <= 1'b0;
            out_hit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            hit_reg   <= hit_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_found_reg <= found_reg;
                out_hit_reg   <= hit_reg;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cyc_reg    <= cyc_next;
        slot_reg   <= slot_next;
        recomp_reg <= recomp_next;
        holds_reg  <= holds_next;
        known_reg  <= known_next;
        acc_reg    <= acc_next;
    end
endmodule

[hdl/act_checker.sv]
// ----------------------------------------------------------------------------
// act_checker
// port-level checks for the arbitrage cycle tracker
// ----------------------------------------------------------------------------
module act_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        found,
    input logic [act_pkg::CYCLE_W-1:0] hit_cycle
);
    import act_pkg::*;

    // handshake outputs always driven
    a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid})) else $error("handshake output unknown");

    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");

    a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (hit_cycle == '0)) else $error("hit without found");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(found) && $stable(hit_cycle)))
        else $error("result dropped");
endmodule

bind arbitrage_cycle_tracker_top act_checker u_act_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .hit_cycle (hit_cycle)
);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the arbitrage cycle tracker: loads cycle slots,
// updates rates and queries new rates under random idling, and checks each
// result against a behavioural rate/profit table kept alongside
// ----------------------------------------------------------------------------
module tb;
    import act_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NP = NUM_PAIRS_DEF;
    localparam int NC = NUM_CYCLES_DEF;
    localparam int CL = CYCLE_LEN_DEF;
    localparam int FB = RATE_FRAC_BITS_DEF;
    localparam logic [31:0] RATE_ONE = 32'd1 << FB;
    localparam int QUIET_LIMIT = 60000;
    localparam int PHASE_ITEMS = 108;

    typedef struct {
        func_t       fn;
        logic [5:0]  pr;
        logic [31:0] rt;
        logic [7:0]  cy;
        logic [1:0]  sl;
        logic        su;
    } tracker_item_t;

    typedef struct {
        logic       fnd;
        logic [7:0] hit;
    } hit_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [FUNC_W-1:0] func = '0;
    logic [PAIR_W-1:0] pair = '0;
    logic [RATE_W-1:0] rate = '0;
    logic [CYCLE_W-1:0] cycle = '0;
    logic [SLOT_W-1:0] slot = '0;
    logic slot_used = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic found;
    logic [CYCLE_W-1:0] hit_cycle;

    always #1 clk = ~clk;

    arbitrage_cycle_tracker_top DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .pair(pair), .rate(rate), .cycle(cycle), .slot(slot),
        .slot_used(slot_used),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .hit_cycle(hit_cycle)
    );

    // behavioural copy of the tracker tables
    logic [31:0] rate_tab [NP];
    logic        rate_ok  [NP];
    logic [5:0]  mem_pair [NC*CL];
    logic        mem_used [NC*CL];
    logic [31:0] profit   [NC];
    logic        profit_ok[NC];
    int unsigned scan_limit;

    tracker_item_t pending_items[$];
    hit_report_t   expected_hits[$];
    int errors = 0;
    int n_hits = 0;
    int n_results = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int quiet = 0;

    function automatic void queue_item(tracker_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void recompute_profit(int c);
        logic [63:0] prod;
        logic [31:0] acc;
        logic ok;
        int idx;
        acc = RATE_ONE;
        ok = 1'b1;
        for (int s = 0; s < CL; s++) begin
            idx = c*CL + s;
            if (mem_used[idx]) begin
                if (!rate_ok[mem_pair[idx]]) begin
                    ok = 1'b0;
                    break;
                end
                prod = ({32'd0, acc} * {32'd0, rate_tab[mem_pair[idx]]}) >> FB;
                acc = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
            end
        end
        profit_ok[c] = ok;
        profit[c] = ok ? acc : 32'd0;
    endfunction

    function automatic logic cycle_has_pair(int c, logic [5:0] p);
        for (int s = 0; s < CL; s++)
            if (mem_used[c*CL+s] && mem_pair[c*CL+s] == p)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic hit_report_t track_item(tracker_item_t it);
        hit_report_t r;
        logic [63:0] rhs;
        int lim;
        r.fnd = 1'b0;
        r.hit = '0;
        case (it.fn)
            FUNC_LOAD: begin
                mem_pair[it.cy*CL + it.sl] = it.pr;
                mem_used[it.cy*CL + it.sl] = it.su;
                recompute_profit(int'(it.cy));
            end
            FUNC_UPDATE: begin
                rate_tab[it.pr] = it.rt;
                rate_ok[it.pr] = 1'b1;
                for (int c = 0; c < NC; c++)
                    if (cycle_has_pair(c, it.pr))
                        recompute_profit(c);
            end
            FUNC_QUERY: begin
                if (rate_ok[it.pr]) begin
                    lim = (scan_limit < NC) ? scan_limit : NC;
                    rhs = 64'({rate_tab[it.pr], {FB{1'b0}}});
                    for (int c = 0; c < lim; c++) begin
                        if (profit_ok[c] && cycle_has_pair(c, it.pr)
                            && ({32'd0, profit[c]} * {32'd0, it.rt} > rhs)) begin
                            r.fnd = 1'b1;
                            r.hit = c[7:0];
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic tracker_item_t mk(func_t f, int p, logic [31:0] r, int c, int s,
                                         int u);
        tracker_item_t it;
        it.fn = f; it.pr = p[5:0]; it.rt = r; it.cy = c[7:0]; it.sl = s[1:0]; it.su = (u != 0);
        return it;
    endfunction

    // rates near 1.0 so that cycles sit close to break-even
    function automatic logic [31:0] near_one();
        int k;
        k = $urandom_range(99);
        if (k < 8) return $urandom;
        if (k < 12) return 32'd0;
        if (k < 15) return 32'hFFFF_FFFF;
        return RATE_ONE + $urandom_range(8192) - 4096;
    endfunction

    function automatic tracker_item_t random_item();
        tracker_item_t it;
        int k;
        int p;
        k = $urandom_range(99);
        p = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(7);
        it = mk(FUNC_LOAD, p, $urandom, 0, $urandom_range(3), 1);
        if (k < 35) begin
            it.cy = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(23));
            it.su = ($urandom_range(4) != 0);
        end else if (k < 62) begin
            it.fn = FUNC_UPDATE;
            it.rt = near_one();
        end else if (k < 95) begin
            it.fn = FUNC_QUERY;
            it.rt = near_one();
            it.cy = 8'($urandom);
        end else begin
            it.fn = FUNC_NONE;
        end
        return it;
    endfunction

    // driver
    always @(posedge clk) begin
        if (rst_n && (!in_valid || in_ready)) begin
            if (in_valid)
                expected_hits.insert(expected_hits.size(),
                                     track_item('{func_t'(func), pair, rate, cycle,
                                                  slot, slot_used}));
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                tracker_item_t it;
                it = pending_items.pop_front();
                in_valid <= 1'b1;
                func <= it.fn;
                pair <= it.pr;
                rate <= it.rt;
                cycle <= it.cy;
                slot <= it.sl;
                slot_used <= it.su;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver with an optional long hold-off
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            n_results++;
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result found=%0b hit_cycle=%0d",
                         $realtime, found, hit_cycle);
                errors++;
            end else begin
                hit_report_t e;
                e = expected_hits.pop_front();
                if (e.fnd) n_hits++;
                if (found !== e.fnd) begin
                    $display("%0t: found expected %0b actual %0b", $realtime, e.fnd, found);
                    errors++;
                end
                if (hit_cycle !== e.hit) begin
                    $display("%0t: hit_cycle expected %0d actual %0d",
                             $realtime, e.hit, hit_cycle);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item on any channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, quiet);
            $display("arbitrage_cycle_tracker_top verification failed");
            $finish;
        end
    end

    task automatic write_cycles_in_use(logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        scan_limit = 32'(v);
    endtask

    initial begin
        int cfg_vals[5];
        int idle_mode[5];
        cfg_vals = '{256, 255, 1, 0, 511};
        idle_mode = '{0, 1, 2, 3, 0};
        for (int i = 0; i < NP; i++) begin
            rate_tab[i] = '0;
            rate_ok[i] = 1'b0;
        end
        for (int i = 0; i < NC*CL; i++) begin
            mem_pair[i] = '0;
            mem_used[i] = 1'b0;
        end
        for (int i = 0; i < NC; i++) begin
            profit[i] = '0;
            profit_ok[i] = 1'b0;
        end
        scan_limit = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 5; ph++) begin
            int n;
            n = PHASE_ITEMS;
            write_cycles_in_use(CFG_W'(cfg_vals[ph]));
            case (idle_mode[ph])
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 74; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 74; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (ph == 0) begin
                // query before any rate is known, then a full cycle of four pairs
                queue_item(mk(FUNC_QUERY, 0, RATE_ONE, 0, 0, 0));
                for (int s = 0; s < 4; s++)
                    queue_item(mk(FUNC_LOAD, s, 0, 0, s, 1));
                for (int s = 0; s < 4; s++)
                    queue_item(mk(FUNC_UPDATE, s, RATE_ONE, 0, 0, 0));
                queue_item(mk(FUNC_QUERY, 1, RATE_ONE + 1, 0, 0, 0));
                queue_item(mk(FUNC_QUERY, 1, RATE_ONE, 0, 0, 0));
                // saturating product
                queue_item(mk(FUNC_UPDATE, 0, 32'hFFFF_FFFF, 0, 0, 0));
                queue_item(mk(FUNC_UPDATE, 1, 32'hFFFF_FFFF, 0, 0, 0));
                queue_item(mk(FUNC_QUERY, 2, 32'hFFFF_FFFF, 0, 0, 0));
                // member with unknown rate, emptied slot, top cycle and slot
                queue_item(mk(FUNC_LOAD, 10, 0, 1, 0, 1));
                queue_item(mk(FUNC_LOAD, 3, 0, 0, 3, 0));
                queue_item(mk(FUNC_LOAD, 63, 32'hFFFF_FFFF, 255, 3, 1));
                // old rate zero
                queue_item(mk(FUNC_UPDATE, 63, 0, 0, 0, 0));
                queue_item(mk(FUNC_QUERY, 63, 32'hFFFF_FFFF, 0, 0, 0));
                queue_item(mk(FUNC_QUERY, 10, RATE_ONE, 0, 0, 0));
                queue_item(mk(FUNC_NONE, 63, 32'hFFFF_FFFF, 255, 3, 1));
                queue_item(mk(FUNC_QUERY, 3, 32'hFFFF_FFFF, 0, 0, 0));
                n -= 22;
                hold_left = 3000;
            end
            repeat (n) queue_item(random_item());
            while (pending_items.size() > 0 || in_valid || expected_hits.size() > 0)
                @(posedge clk);
            repeat (20) @(posedge clk);
        end

        repeat (100) @(posedge clk);
        $display("ran %0d items over 5 settings of cycles_in_use and 4 idling modes", 5*PHASE_ITEMS);
        $display("%0d results checked, %0d of them profitable hits", n_results, n_hits);
        if (errors == 0 && expected_hits.size() == 0)
            $display("arbitrage_cycle_tracker_top verification clean");
        else
            $display("arbitrage_cycle_tracker_top verification failed");
        $finish;
    end

endmodule

[files.f]
hdl/act_pkg.sv
hdl/act_mul.sv
hdl/arbitrage_cycle_tracker_top.sv
hdl/act_checker.sv
tb/sv/tb.sv
